### hw/rtl/gmat_pkg.sv
package gmat_pkg;

  localparam int EVENT_W          = 16;
  localparam int COORD_W          = 7;
  localparam int RADIUS_W         = 8;
  localparam int RSQ_W            = 2 * RADIUS_W;
  localparam int SQ_W             = 2 * COORD_W;
  localparam int DIST_W           = SQ_W + 1;
  localparam int WINDOW_DEPTH_DEF = 16;

  localparam int Y_LSB   = 0;
  localparam int POL_BIT = 7;
  localparam int X_LSB   = 8;

  localparam logic [RADIUS_W-1:0] RADIUS_RESET = 8'd100;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
  } sample_t;

endpackage

### hw/rtl/gated_moving_average_tracker_unit.sv
// Tracks one object from a stream of camera event words. Each transfer in
// gives exactly one result, which is offered on the output from the next
// cycle, and a new event can be taken in every unstalled cycle; the sustained
// rate of one event per cycle is set by the gate check and the running-sum
// update, which both finish in the cycle of the transfer against registered
// averages. The window is a row of WINDOW_DEPTH shift cells, so the oldest
// sample is always at the end of the row. The result waits in an output
// register, and the input is stalled only while that register is full and
// stalled. Reset clears the whole window at once, and a write to the gate
// radius takes effect from the next cycle.
module gated_moving_average_tracker_unit #(
  parameter int WINDOW_DEPTH = gmat_pkg::WINDOW_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [gmat_pkg::EVENT_W-1:0]  in_event_word,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [gmat_pkg::COORD_W-1:0]  out_x_position,
  output logic [gmat_pkg::COORD_W-1:0]  out_y_position,
  output logic                          out_locked,
  output logic                          out_accepted,
  input  logic                          cfg_wr_en,
  input  logic [gmat_pkg::RADIUS_W-1:0] cfg_wr_data
);
  import gmat_pkg::*;

  localparam int SLOT_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int SUM_W  = COORD_W + SLOT_W;
  localparam logic [SLOT_W-1:0] LAST_SLOT  = SLOT_W'(WINDOW_DEPTH - 1);
  localparam logic [RSQ_W-1:0]  RSQ_RESET  = RSQ_W'(RADIUS_RESET) * RSQ_W'(RADIUS_RESET);

  logic [RSQ_W-1:0]   rsq_r, rsq_nxt;
  logic [SUM_W-1:0]   x_sum_r, x_sum_nxt;
  logic [SUM_W-1:0]   y_sum_r, y_sum_nxt;
  logic [COORD_W-1:0] x_avg_r, x_avg_nxt;
  logic [COORD_W-1:0] y_avg_r, y_avg_nxt;
  logic [SLOT_W-1:0]  slot_r, slot_nxt;
  logic               full_r, full_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [COORD_W-1:0] out_x_r, out_y_r;
  logic               out_locked_r, out_accepted_r;

  logic    accept;
  logic    offer;
  logic    take;
  logic    inside_gate;
  sample_t sample;
  sample_t oldest;
  sample_t chain [WINDOW_DEPTH+1];

  assign accept   = in_valid && !in_stall;
  assign in_stall = out_valid_r && out_stall;

  assign sample.x = in_event_word[X_LSB +: COORD_W];
  assign sample.y = in_event_word[Y_LSB +: COORD_W];
  assign offer    = accept && in_event_word[POL_BIT];

  gmat_gate u_gate (
    .avg_x       (x_avg_r),
    .avg_y       (y_avg_r),
    .sample      (sample),
    .radius_sq   (rsq_r),
    .inside_gate (inside_gate)
  );

  assign take = offer && (!full_r || inside_gate);

  assign chain[0] = sample;

  for (genvar i = 0; i < WINDOW_DEPTH; i++) begin : g_cell
    gmat_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .shift_en   (take),
      .sample_in  (chain[i]),
      .sample_out (chain[i+1])
    );
  end

  assign oldest = chain[WINDOW_DEPTH];

  always_comb begin
    rsq_nxt   = cfg_wr_en ? (RSQ_W'(cfg_wr_data) * RSQ_W'(cfg_wr_data)) : rsq_r;
    x_sum_nxt = x_sum_r;
    y_sum_nxt = y_sum_r;
    slot_nxt  = slot_r;
    full_nxt  = full_r;
    if (take) begin
      x_sum_nxt = x_sum_r - SUM_W'(oldest.x) + SUM_W'(sample.x);
      y_sum_nxt = y_sum_r - SUM_W'(oldest.y) + SUM_W'(sample.y);
      slot_nxt  = (slot_r == LAST_SLOT) ? '0 : slot_r + 1'b1;
      if (slot_r == LAST_SLOT) begin
        full_nxt = 1'b1;
      end
    end
    x_avg_nxt = COORD_W'(x_sum_nxt / WINDOW_DEPTH);
    y_avg_nxt = COORD_W'(y_sum_nxt / WINDOW_DEPTH);
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = out_valid_r && out_stall;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rsq_r       <= RSQ_RESET;
      x_sum_r     <= '0;
      y_sum_r     <= '0;
      x_avg_r     <= '0;
      y_avg_r     <= '0;
      slot_r      <= '0;
      full_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rsq_r       <= rsq_nxt;
      x_sum_r     <= x_sum_nxt;
      y_sum_r     <= y_sum_nxt;
      x_avg_r     <= x_avg_nxt;
      y_avg_r     <= y_avg_nxt;
      slot_r      <= slot_nxt;
      full_r      <= full_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_x_r        <= x_avg_nxt;
      out_y_r        <= y_avg_nxt;
      out_locked_r   <= full_nxt;
      out_accepted_r <= take;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_x_position = out_x_r;
  assign out_y_position = out_y_r;
  assign out_locked     = out_locked_r;
  assign out_accepted   = out_accepted_r;

  a_avg_tracks_sum: assert property (@(posedge clk) disable iff (!rst_n)
    x_avg_r == COORD_W'(x_sum_r / WINDOW_DEPTH) && y_avg_r == COORD_W'(y_sum_r / WINDOW_DEPTH))
    else $error("Registered average does not match the running sum.");

  a_lock_on_last_slot: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(full_r) |-> $past(slot_r) == LAST_SLOT && $past(take))
    else $error("Lock set without a sample in the last slot.");

  a_lock_holds: assert property (@(posedge clk) disable iff (!rst_n)
    full_r |=> full_r)
    else $error("Lock dropped after being set.");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid_r && out_accepted_r == $past(take) && out_locked_r == full_r)
    else $error("Result register does not hold the transfer just taken.");

endmodule

### hw/rtl/gmat_cell.sv
module gmat_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              shift_en,
  input  gmat_pkg::sample_t sample_in,
  output gmat_pkg::sample_t sample_out
);
  import gmat_pkg::*;

  sample_t sample_r;
  sample_t sample_nxt;

  always_comb begin
    sample_nxt = shift_en ? sample_in : sample_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_r <= '0;
    end else begin
      sample_r <= sample_nxt;
    end
  end

  assign sample_out = sample_r;

endmodule

### hw/rtl/gmat_gate.sv
module gmat_gate (
  input  logic [gmat_pkg::COORD_W-1:0] avg_x,
  input  logic [gmat_pkg::COORD_W-1:0] avg_y,
  input  gmat_pkg::sample_t            sample,
  input  logic [gmat_pkg::RSQ_W-1:0]   radius_sq,
  output logic                         inside_gate
);
  import gmat_pkg::*;

  logic [COORD_W-1:0] dx_abs;
  logic [COORD_W-1:0] dy_abs;
  logic [SQ_W-1:0]    dx_sq;
  logic [SQ_W-1:0]    dy_sq;
  logic [DIST_W-1:0]  dist_sq;

  always_comb begin
    dx_abs  = (avg_x >= sample.x) ? (avg_x - sample.x) : (sample.x - avg_x);
    dy_abs  = (avg_y >= sample.y) ? (avg_y - sample.y) : (sample.y - avg_y);
    dx_sq   = SQ_W'(dx_abs) * SQ_W'(dx_abs);
    dy_sq   = SQ_W'(dy_abs) * SQ_W'(dy_abs);
    dist_sq = DIST_W'(dx_sq) + DIST_W'(dy_sq);
    inside_gate = RSQ_W'(dist_sq) < radius_sq;
  end

endmodule
